// File: sv/rlfw_pkg.sv
package rlfw_pkg;

    // sizes of the lock manager
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_THREADS = 256;
    localparam int TID_W       = 8;
    localparam int DEPTH_W     = 8;
    localparam int FILL_W      = 5;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int FLAG_W      = $clog2(MAX_THREADS);

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // command codes
    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    // result codes
    typedef enum logic [3:0] {
        STAT_ACQUIRED       = 4'd0,
        STAT_NESTED         = 4'd1,
        STAT_QUEUED         = 4'd2,
        STAT_REL_NESTED     = 4'd3,
        STAT_FREED          = 4'd4,
        STAT_HANDED         = 4'd5,
        STAT_NOT_HOLDER     = 4'd6,
        STAT_QUEUE_FULL     = 4'd7,
        STAT_ALREADY_WAIT   = 4'd8,
        STAT_DEPTH_OVERFLOW = 4'd9
    } status_t;

    // commands into the wait queue
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [TID_W-1:0] push_id;
    } waitq_ctrl_t;

    // wait queue lookup results
    typedef struct packed {
        logic [TID_W-1:0] head_id;
        logic             waiting;
        logic [CNT_W-1:0] count;
    } waitq_stat_t;

endpackage

// File: sv/rlfw_waitq.sv
module rlfw_waitq
    import rlfw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             lookup,
    input  logic [TID_W-1:0] lookup_id,
    input  waitq_ctrl_t      ctrl,
    output waitq_stat_t      stat
);

    // waiter id ring and per-thread waiting flags
    logic [TID_W-1:0]       queue_mem [QUEUE_DEPTH];
    logic                   flag_mem  [MAX_THREADS];
    logic [MAX_THREADS-1:0] flag_vld_reg;

    logic [QIDX_W-1:0] head_reg;
    logic [QIDX_W-1:0] tail_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [TID_W-1:0]  head_id_reg;
    logic              flag_rd_reg;
    logic              flag_vld_rd_reg;

    logic [FLAG_W-1:0] lookup_idx;
    logic [FLAG_W-1:0] flag_wr_idx;

    // ids wrap modulo the flag table size
    assign lookup_idx  = FLAG_W'(lookup_id);
    assign flag_wr_idx = ctrl.push ? FLAG_W'(ctrl.push_id) : FLAG_W'(head_id_reg);

    function automatic logic [QIDX_W-1:0] next_slot(input logic [QIDX_W-1:0] pos);
        return (pos == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

    // ring memory: write at tail, read at head on lookup
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            queue_mem[tail_reg] <= ctrl.push_id;
        end
        if (lookup)
        begin
            head_id_reg <= queue_mem[head_reg];
        end
    end

    // flag memory: set on push, cleared for the head on pop
    always_ff @(posedge clk)
    begin
        if (ctrl.push || ctrl.pop)
        begin
            flag_mem[flag_wr_idx] <= ctrl.push;
        end
        if (lookup)
        begin
            flag_rd_reg <= flag_mem[lookup_idx];
        end
    end

    // valid bits stand in for the cleared flag table after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_vld_reg    <= '0;
            flag_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.push || ctrl.pop)
            begin
                flag_vld_reg[flag_wr_idx] <= 1'b1;
            end
            if (lookup)
            begin
                flag_vld_rd_reg <= flag_vld_reg[lookup_idx];
            end
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctrl.push)
        begin
            tail_reg  <= next_slot(tail_reg);
            count_reg <= count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            head_reg  <= next_slot(head_reg);
            count_reg <= count_reg - 1'b1;
        end
    end

    assign stat.head_id = head_id_reg;
    assign stat.waiting = flag_rd_reg & flag_vld_rd_reg;
    assign stat.count   = count_reg;

endmodule

// File: sv/recursive_lock_fifo_waiters_unit.sv
// channel | direction | handshake          | payload
// input   | in        | in_valid, in_stall | cmd, thread_id
// output  | out       | out_valid, out_stall | status, owner_id, lock_busy, nesting, queue_fill
//
// each request first reads the wait queue head and the requester's waiting
// flag from their memories, then decides and writes back.
// a new request is not taken until the last one has been decided.
// reset clears the lock, the queue pointers and all waiting flags at once.
// a held result stalls the decide cycle; the next request waits behind it.
module recursive_lock_fifo_waiters_unit
    import rlfw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [TID_W-1:0]   thread_id,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         status,
    output logic [TID_W-1:0]   owner_id,
    output logic               lock_busy,
    output logic [DEPTH_W-1:0] nesting,
    output logic [FILL_W-1:0]  queue_fill
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t             state_reg;
    logic               cmd_reg;
    logic [TID_W-1:0]   tid_reg;
    logic [TID_W-1:0]   holder_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic               held_reg;
    logic               out_valid_reg;
    status_t            status_reg;
    logic [FILL_W-1:0]  fill_reg;

    logic               accept;
    logic               fire;
    status_t            status_next;
    logic [TID_W-1:0]   holder_next;
    logic [DEPTH_W-1:0] depth_next;
    logic               held_next;
    logic [CNT_W-1:0]   count_next;
    waitq_ctrl_t        q_ctrl;
    waitq_stat_t        q_stat;

    assign in_stall = (state_reg == ST_EXEC);
    assign accept   = in_valid && !in_stall;
    assign fire     = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);

    rlfw_waitq u_waitq (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup    (accept),
        .lookup_id (thread_id),
        .ctrl      (q_ctrl),
        .stat      (q_stat)
    );

    // lock decision for the request in flight
    always_comb
    begin
        status_next    = STAT_NOT_HOLDER;
        holder_next    = holder_reg;
        depth_next     = depth_reg;
        held_next      = held_reg;
        q_ctrl.push    = 1'b0;
        q_ctrl.pop     = 1'b0;
        q_ctrl.push_id = tid_reg;
        if (cmd_reg == CMD_ACQUIRE)
        begin
            if (held_reg && holder_reg == tid_reg)
            begin
                if (depth_reg == DEPTH_MAX)
                begin
                    status_next = STAT_DEPTH_OVERFLOW;
                end
                else
                begin
                    status_next = STAT_NESTED;
                    depth_next  = depth_reg + 1'b1;
                end
            end
            else if (!held_reg)
            begin
                status_next = STAT_ACQUIRED;
                held_next   = 1'b1;
                holder_next = tid_reg;
                depth_next  = DEPTH_W'(1);
            end
            else if (q_stat.waiting)
            begin
                status_next = STAT_ALREADY_WAIT;
            end
            else if (q_stat.count == CNT_W'(QUEUE_DEPTH))
            begin
                status_next = STAT_QUEUE_FULL;
            end
            else
            begin
                status_next = STAT_QUEUED;
                q_ctrl.push = fire;
            end
        end
        else
        begin
            if (!held_reg || holder_reg != tid_reg)
            begin
                status_next = STAT_NOT_HOLDER;
            end
            else if (depth_reg > DEPTH_W'(1))
            begin
                status_next = STAT_REL_NESTED;
                depth_next  = depth_reg - 1'b1;
            end
            else if (q_stat.count == '0)
            begin
                status_next = STAT_FREED;
                held_next   = 1'b0;
                holder_next = '0;
                depth_next  = '0;
            end
            else
            begin
                // last release passes the lock to the queue head
                status_next = STAT_HANDED;
                holder_next = q_stat.head_id;
                depth_next  = DEPTH_W'(1);
                q_ctrl.pop  = fire;
            end
        end
    end

    // fill count after this request
    always_comb
    begin
        count_next = q_stat.count;
        if (status_next == STAT_QUEUED)
        begin
            count_next = q_stat.count + 1'b1;
        end
        else if (status_next == STAT_HANDED)
        begin
            count_next = q_stat.count - 1'b1;
        end
    end

    // sequencer, lock state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            holder_reg    <= '0;
            depth_reg     <= '0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // result valid: set on a decision, cleared on its transfer
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (fire)
                    begin
                        state_reg  <= ST_IDLE;
                        holder_reg <= holder_next;
                        depth_reg  <= depth_next;
                        held_reg   <= held_next;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            tid_reg <= thread_id;
        end
        if (fire)
        begin
            status_reg <= status_next;
            fill_reg   <= FILL_W'(count_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign owner_id   = holder_reg;
    assign lock_busy  = held_reg;
    assign nesting    = depth_reg;
    assign queue_fill = fill_reg;

endmodule

// File: sim/recursive_lock_fifo_waiters_unit_tb.sv
module recursive_lock_fifo_waiters_unit_tb;
    import rlfw_pkg::*;

    localparam int REQUEST_TARGET  = 1600;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int POOL_MAX        = 24;

    // one lock manager response
    typedef struct {
        status_t            status;
        logic [TID_W-1:0]   owner;
        logic               busy;
        logic [DEPTH_W-1:0] nest;
        logic [FILL_W-1:0]  fill;
    } lock_result_t;

    // lock state tracker and response checker
    class lock_scoreboard;
        logic [TID_W-1:0]   holder;
        logic [DEPTH_W-1:0] depth;
        logic               held;
        logic [TID_W-1:0]   waiters [QUEUE_DEPTH];
        int                 qhead;
        int                 qtail;
        int                 qcount;
        bit                 waiting [MAX_THREADS];
        lock_result_t       outcomes [$];
        int                 errors;

        function new();
            holder = '0;
            depth  = '0;
            held   = 1'b0;
            qhead  = 0;
            qtail  = 0;
            qcount = 0;
            errors = 0;
            foreach (waiting[i])
                waiting[i] = 1'b0;
        endfunction

        // acquire: nest, take a free lock, or join the wait queue
        function status_t grant(logic [TID_W-1:0] tid);
            if (held && holder == tid) begin
                if (depth == DEPTH_MAX)
                    return STAT_DEPTH_OVERFLOW;
                depth++;
                return STAT_NESTED;
            end
            if (!held) begin
                held   = 1'b1;
                holder = tid;
                depth  = DEPTH_W'(1);
                return STAT_ACQUIRED;
            end
            if (waiting[tid])
                return STAT_ALREADY_WAIT;
            if (qcount >= QUEUE_DEPTH)
                return STAT_QUEUE_FULL;
            waiters[qtail] = tid;
            qtail = (qtail + 1) % QUEUE_DEPTH;
            qcount++;
            waiting[tid] = 1'b1;
            return STAT_QUEUED;
        endfunction

        // release: unnest, free, or hand over to the queue head
        function status_t drop(logic [TID_W-1:0] tid);
            logic [TID_W-1:0] next_id;
            if (!held || holder != tid)
                return STAT_NOT_HOLDER;
            if (depth > 1) begin
                depth--;
                return STAT_REL_NESTED;
            end
            if (qcount == 0) begin
                held   = 1'b0;
                holder = '0;
                depth  = '0;
                return STAT_FREED;
            end
            next_id = waiters[qhead];
            qhead = (qhead + 1) % QUEUE_DEPTH;
            qcount--;
            waiting[next_id] = 1'b0;
            holder = next_id;
            depth  = DEPTH_W'(1);
            return STAT_HANDED;
        endfunction

        function void note_request(cmd_t c, logic [TID_W-1:0] tid);
            lock_result_t r;
            r.status = (c == CMD_ACQUIRE) ? grant(tid) : drop(tid);
            r.owner  = held ? holder : '0;
            r.busy   = held;
            r.nest   = depth;
            r.fill   = FILL_W'(qcount);
            outcomes.push_back(r);
        endfunction

        function void check_result(logic [3:0] st, logic [TID_W-1:0] own, logic busy,
                                   logic [DEPTH_W-1:0] nest, logic [FILL_W-1:0] fill);
            lock_result_t want;
            if (outcomes.size() == 0) begin
                $error("response with no request outstanding: status %0d", st);
                errors++;
                return;
            end
            want = outcomes.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
            if (own !== want.owner) begin
                $error("owner_id: expected %0d, actual %0d", want.owner, own);
                errors++;
            end
            if (busy !== want.busy) begin
                $error("lock_busy: expected %0d, actual %0d", want.busy, busy);
                errors++;
            end
            if (nest !== want.nest) begin
                $error("nesting: expected %0d, actual %0d", want.nest, nest);
                errors++;
            end
            if (fill !== want.fill) begin
                $error("queue_fill: expected %0d, actual %0d", want.fill, fill);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               cmd;
    logic [TID_W-1:0]   thread_id;
    logic               out_valid;
    logic               out_stall;
    logic [3:0]         status;
    logic [TID_W-1:0]   owner_id;
    logic               lock_busy;
    logic [DEPTH_W-1:0] nesting;
    logic [FILL_W-1:0]  queue_fill;

    lock_scoreboard sb;
    int             requests_sent = 0;
    int             cycles = 0;
    bit             eager = 1'b0;
    bit             hold_off_req = 1'b0;

    recursive_lock_fifo_waiters_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .thread_id  (thread_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .owner_id   (owner_id),
        .lock_busy  (lock_busy),
        .nesting    (nesting),
        .queue_fill (queue_fill)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // response side: check each transfer, then pick the next stall
    initial
    begin
        int r;
        int hold_left;
        int burst_left;
        int quiet_left;
        hold_left  = 0;
        burst_left = 0;
        quiet_left = 0;
        out_stall  = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(status, owner_id, lock_busy, nesting, queue_fill);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (burst_left > 0) begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else begin
                out_stall <= 1'b0;
                if (quiet_left > 0)
                    quiet_left--;
                else begin
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        burst_left = $urandom_range(1, 3);
                    else if (r < 12)
                        burst_left = $urandom_range(10, 40);
                    else if (r < 15)
                        quiet_left = $urandom_range(30, 150);
                end
            end
        end
    end

    // idle cycles before a request, mostly none or short
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (eager)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // offer one request and wait for its transfer
    task automatic send(cmd_t c, logic [TID_W-1:0] tid);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        thread_id <= tid;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(c, tid);
        requests_sent++;
    endtask

    // pause requests until every response is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outcomes.size() != 0)
            @(posedge clk);
    endtask

    // holder keeps releasing until the lock is free, handing over along the way
    task automatic release_all();
        while (sb.held)
            send(CMD_RELEASE, sb.holder);
    endtask

    // every status but queue full and depth overflow, id extremes
    task automatic run_directed();
        send(CMD_RELEASE, 8'h00);
        send(CMD_ACQUIRE, 8'h00);
        send(CMD_ACQUIRE, 8'h00);
        send(CMD_RELEASE, 8'hFF);
        send(CMD_ACQUIRE, 8'hFF);
        send(CMD_ACQUIRE, 8'hFF);
        send(CMD_ACQUIRE, 8'hAA);
        send(CMD_RELEASE, 8'h00);
        send(CMD_RELEASE, 8'h00);
        send(CMD_RELEASE, 8'h00);
        send(CMD_ACQUIRE, 8'h55);
        send(CMD_RELEASE, 8'hFF);
        send(CMD_RELEASE, 8'hAA);
        send(CMD_RELEASE, 8'h55);
        send(CMD_ACQUIRE, 8'h55);
        send(CMD_RELEASE, 8'h55);
    endtask

    // a small set of threads fighting over the lock
    task automatic run_contention(int count);
        logic [TID_W-1:0] pool [POOL_MAX];
        logic [TID_W-1:0] tid;
        int               pool_size;
        int               r;
        pool_size = $urandom_range(2, POOL_MAX);
        foreach (pool[i])
            pool[i] = TID_W'($urandom_range(0, 255));
        repeat (count) begin
            r   = $urandom_range(0, 99);
            tid = pool[$urandom_range(0, pool_size - 1)];
            if (r < 40 && sb.held)
                send(CMD_RELEASE, sb.holder);
            else if (r < 85)
                send(CMD_ACQUIRE, tid);
            else if (r < 95)
                send(CMD_RELEASE, tid);
            else
                send(cmd_t'($urandom_range(0, 1)), TID_W'($urandom_range(0, 255)));
        end
    endtask

    // fill the wait queue up to or past full with distinct threads, then drain it
    task automatic run_queue_fill();
        bit               taken [MAX_THREADS];
        logic [TID_W-1:0] tid;
        release_all();
        foreach (taken[i])
            taken[i] = 1'b0;
        tid = TID_W'($urandom_range(0, 255));
        taken[tid] = 1'b1;
        send(CMD_ACQUIRE, tid);
        repeat ($urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 4)) begin
            do
                tid = TID_W'($urandom_range(0, 255));
            while (taken[tid]);
            taken[tid] = 1'b1;
            send(CMD_ACQUIRE, tid);
            // retry by the same thread
            if ($urandom_range(0, 7) == 0)
                send(CMD_ACQUIRE, tid);
        end
        release_all();
    endtask

    // nest up to the depth limit and past it, then unwind with some interference
    task automatic run_deep_nest();
        logic [TID_W-1:0] tid;
        release_all();
        tid = TID_W'($urandom_range(0, 255));
        repeat (256 + $urandom_range(0, 2))
            send(CMD_ACQUIRE, tid);
        while (sb.held) begin
            if ($urandom_range(0, 9) == 0)
                send(CMD_ACQUIRE, TID_W'($urandom_range(0, 255)));
            else
                send(CMD_RELEASE, sb.holder);
        end
    endtask

    // main sequence
    initial
    begin
        int pick;
        in_valid  = 1'b0;
        cmd       = CMD_ACQUIRE;
        thread_id = '0;
        rst_n     = 1'b0;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();

        // long response hold-off while requests keep coming
        hold_off_req = 1'b1;
        eager = 1'b1;
        run_contention(60);
        eager = 1'b0;

        run_queue_fill();
        run_deep_nest();
        wait_drained();

        while (requests_sent < REQUEST_TARGET) begin
            pick  = $urandom_range(0, 99);
            eager = ($urandom_range(0, 4) == 0);
            if (pick < 75)
                run_contention($urandom_range(20, 80));
            else if (pick < 88)
                run_queue_fill();
            else if (pick < 97)
                wait_drained();
            else begin
                hold_off_req = 1'b1;
                run_contention(40);
            end
        end
        eager = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outcomes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
sv/rlfw_pkg.sv
sv/rlfw_waitq.sv
sv/recursive_lock_fifo_waiters_unit.sv
sim/recursive_lock_fifo_waiters_unit_tb.sv
